/* rtl/sobel_edge_magnitude_assert.svh */
// Assertion macros used by the top RTL file of the edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sem_pkg.sv */
`default_nettype none

package sem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 11;
   localparam int PIX_W      = 24;
   localparam int MAG_W      = 15;
   localparam int ROOT_W     = 19;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int NUM_CH     = 3;

   localparam logic [1:0] CSR_COLOR_MODE   = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_GAIN         = 2'd3;

   typedef logic [2:0][2:0][7:0] sem_win_type;

   typedef struct packed {
      logic        start;
      sem_win_type win;
   } sem_lane_ctrl_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] mag;
   } sem_lane_status_type;

   typedef logic [NUM_CH-1:0][MAG_W-1:0] sem_mag_set_type;

endpackage

`default_nettype wire

/* rtl/sem_ram.sv */
`default_nettype none

module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/sem_lane.sv */
`default_nettype none

module sem_lane (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sem_pkg::sem_lane_ctrl_type  ctrl,
   input  wire logic [15:0]                 gain_sq,
   output sem_pkg::sem_lane_status_type     status
);

   import sem_pkg::*;

   typedef enum logic [2:0] {
      L_IDLE,
      L_SQUARE,
      L_SCALE,
      L_ROOT
   } lane_state_type;

   lane_state_type     state_ff;
   logic signed [10:0] gx_ff;
   logic signed [10:0] gy_ff;
   logic [20:0]        e_ff;
   logic [RAD_W-1:0]   v_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [ROOT_W-1:0]  res_ff;
   logic [4:0]         cnt_ff;
   logic               done_ff;

   logic [9:0]         sum_l;
   logic [9:0]         sum_r;
   logic [9:0]         sum_t;
   logic [9:0]         sum_b;
   logic signed [10:0] gx_in;
   logic signed [10:0] gy_in;
   logic signed [21:0] sqx;
   logic signed [21:0] sqy;
   logic [20:0]        e_in;
   logic [36:0]        prod;
   logic [REM_W+1:0]   rem_sh;
   logic [REM_W+1:0]   trial;

   always_comb begin
      sum_l = {2'b00, ctrl.win[0][0]} + {1'b0, ctrl.win[1][0], 1'b0} + {2'b00, ctrl.win[2][0]};
      sum_r = {2'b00, ctrl.win[0][2]} + {1'b0, ctrl.win[1][2], 1'b0} + {2'b00, ctrl.win[2][2]};
      sum_t = {2'b00, ctrl.win[0][0]} + {1'b0, ctrl.win[0][1], 1'b0} + {2'b00, ctrl.win[0][2]};
      sum_b = {2'b00, ctrl.win[2][0]} + {1'b0, ctrl.win[2][1], 1'b0} + {2'b00, ctrl.win[2][2]};
      gx_in = signed'({1'b0, sum_r}) - signed'({1'b0, sum_l});
      gy_in = signed'({1'b0, sum_b}) - signed'({1'b0, sum_t});
      sqx   = gx_ff * gx_ff;
      sqy   = gy_ff * gy_ff;
      e_in  = sqx[20:0] + sqy[20:0];
      prod  = e_ff * gain_sq;
      rem_sh = {rem_ff, v_ff[RAD_W-1 -: 2]};
      trial  = {2'b00, res_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (ctrl.start) begin
                  gx_ff    <= gx_in;
                  gy_ff    <= gy_in;
                  state_ff <= L_SQUARE;
               end
            end
            L_SQUARE: begin
               e_ff     <= e_in;
               state_ff <= L_SCALE;
            end
            L_SCALE: begin
               v_ff     <= {1'b0, prod};
               rem_ff   <= '0;
               res_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= L_ROOT;
            end
            L_ROOT: begin
               v_ff <= {v_ff[RAD_W-3:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_ff <= REM_W'(rem_sh - trial);
                  res_ff <= {res_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_ff <= REM_W'(rem_sh);
                  res_ff <= {res_ff[ROOT_W-2:0], 1'b0};
               end
               if (cnt_ff == 5'(ROOT_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign status.done = done_ff;
   assign status.mag  = res_ff[ROOT_W-1:4];

endmodule

`default_nettype wire

/* rtl/sem_merge.sv */
`default_nettype none

module sem_merge (
   input  wire logic                     color_mode,
   input  wire sem_pkg::sem_mag_set_type mags,
   output logic [7:0]                    edge_value
);

   import sem_pkg::*;

   logic [MAG_W+1:0] sum;
   logic [19:0]      quot;

   always_comb begin
      sum  = {2'b00, mags[0]} + {2'b00, mags[1]} + {2'b00, mags[2]};
      quot = sum[9:0] * 10'd683;
      if (color_mode) begin
         if (sum >= 17'd768) begin
            edge_value = 8'd255;
         end else begin
            edge_value = quot[18:11];
         end
      end else begin
         if (mags[0] > 15'd255) begin
            edge_value = 8'd255;
         end else begin
            edge_value = mags[0][7:0];
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/sobel_edge_magnitude.sv */
// Streaming 3x3 Sobel edge magnitude over a raster pixel stream.
// Input item: one pixel (three 8-bit channels) on the req_ valid/ready channel,
// in raster order. Output item: row, column, 8-bit edge value and a flag on the
// last pixel of the frame, on the rsp_ valid/ready channel.
// Output (r,c) is produced when input (r+1,c+1) arrives; the last column of a
// row follows the one before it, and the last two rows leave interleaved
// while the last input row arrives, so one input item yields zero to four results.
// One item is processed at a time: the next item is taken only once every result
// of the last one has left. Each result waits for a 19-step bit-serial square
// root in the three channel lanes, and for the receiver while it stalls.
// The CSR port writes color mode, frame width, frame height and gain; the user
// must make writes only while the block is idle, which the block does not enforce.
// Reset clears the window, the row and column counters and the registers to
// their defaults; the line stores need no clearing.
// While the receiver stalls, the result stays on the rsp_ port and no new input
// item is taken.
`default_nettype none

`include "sobel_edge_magnitude_assert.svh"

module sobel_edge_magnitude (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_pixel_ch0,
   input  wire logic [7:0]  req_pixel_ch1,
   input  wire logic [7:0]  req_pixel_ch2,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [9:0]       rsp_out_row,
   output logic [9:0]       rsp_out_col,
   output logic [7:0]       rsp_edge_value,
   output logic             rsp_frame_last,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata
);

   import sem_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_SLOT,
      S_CALC,
      S_OUT
   } top_state_type;

   top_state_type         state_ff;
   logic                  color_mode_ff;
   logic [DIM_W-1:0]      frame_width_ff;
   logic [DIM_W-1:0]      frame_height_ff;
   logic [7:0]            gain_ff;
   logic [15:0]           gain_sq_ff;
   logic [PIX_W-1:0]      cells_ff [9];
   logic [ROW_W-1:0]      row_ff;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      r_ff;
   logic [COL_W-1:0]      c_ff;
   logic [PIX_W-1:0]      pix_ff;
   logic [1:0]            slot_ff;
   logic                  rsp_valid_ff;
   logic [9:0]            rsp_row_ff;
   logic [9:0]            rsp_col_ff;
   logic [7:0]            rsp_edge_ff;
   logic                  rsp_last_ff;

   logic [DIM_W-1:0]      w_eff;
   logic [DIM_W-1:0]      h_eff;
   logic                  wrap_col;
   logic [DIM_W-1:0]      r_tmp;
   logic [COL_W-1:0]      c_cur;
   logic [ROW_W-1:0]      r_cur;
   logic [DIM_W-1:0]      c_next;
   logic [DIM_W-1:0]      r_next;
   logic [COL_W-1:0]      col_in;
   logic [ROW_W-1:0]      row_in;
   logic [PIX_W-1:0]      older_rd;
   logic [PIX_W-1:0]      newer_rd;
   logic                  ram_we;
   logic                  accept;
   logic                  slot_valid;
   logic [DIM_W-1:0]      orow;
   logic [DIM_W-1:0]      ocol;
   logic [1:0]            rowmap [3];
   logic [1:0]            colmap [3];
   logic [3:0]            cidx;
   sem_lane_ctrl_type     lane_ctrl [NUM_CH];
   sem_lane_status_type   lane_status [NUM_CH];
   sem_mag_set_type       mags;
   logic [7:0]            edge_in;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign ram_we    = (state_ff == S_LOAD);

   always_comb begin
      if (frame_width_ff < 11'd2) begin
         w_eff = 11'd2;
      end else if (frame_width_ff > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff < 11'd2) begin
         h_eff = 11'd2;
      end else if (frame_height_ff > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end

      wrap_col = ({1'b0, col_ff} >= w_eff);
      c_cur    = wrap_col ? '0 : col_ff;
      r_tmp    = wrap_col ? ({1'b0, row_ff} + 11'd1) : {1'b0, row_ff};
      r_cur    = (r_tmp >= h_eff) ? '0 : r_tmp[ROW_W-1:0];
      c_next   = {1'b0, c_cur} + 11'd1;
      r_next   = {1'b0, r_cur} + 11'd1;
      if (c_next >= w_eff) begin
         col_in = '0;
         row_in = (r_next >= h_eff) ? '0 : r_next[ROW_W-1:0];
      end else begin
         col_in = c_next[COL_W-1:0];
         row_in = r_cur;
      end
   end

   // Result slots: bit 1 picks the column (c-1 or the last one), bit 0 the row
   // (r-1 or, on the last input row, r itself).
   always_comb begin
      slot_valid = 1'b0;
      if (r_ff != '0 && c_ff != '0) begin
         if (slot_ff[1] == 1'b0 || {1'b0, c_ff} == w_eff - 11'd1) begin
            if (slot_ff[0] == 1'b0 || {1'b0, r_ff} == h_eff - 11'd1) begin
               slot_valid = 1'b1;
            end
         end
      end
      ocol = slot_ff[1] ? (w_eff - 11'd1) : ({1'b0, c_ff} - 11'd1);
      orow = slot_ff[0] ? {1'b0, r_ff} : ({1'b0, r_ff} - 11'd1);

      if (ocol == w_eff - 11'd1) begin
         colmap[0] = 2'd1;
         colmap[1] = 2'd2;
         colmap[2] = 2'd1;
      end else begin
         colmap[0] = (ocol == '0) ? 2'd2 : 2'd0;
         colmap[1] = 2'd1;
         colmap[2] = 2'd2;
      end
      if (slot_ff[0]) begin
         rowmap[0] = 2'd1;
         rowmap[1] = 2'd2;
         rowmap[2] = 2'd1;
      end else begin
         rowmap[0] = (orow == '0) ? 2'd2 : 2'd0;
         rowmap[1] = 2'd1;
         rowmap[2] = 2'd2;
      end

      cidx = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         lane_ctrl[ch].start = (state_ff == S_SLOT) && slot_valid;
         for (int rr = 0; rr < 3; rr++) begin
            for (int cc = 0; cc < 3; cc++) begin
               cidx = 4'({rowmap[rr], 1'b0} + {2'b00, rowmap[rr]}) + {2'b00, colmap[cc]};
               lane_ctrl[ch].win[rr][cc] = cells_ff[cidx][8*ch +: 8];
            end
         end
      end
   end

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (c_ff),
      .wr_data (newer_rd),
      .rd_addr (c_cur),
      .rd_data (older_rd)
   );

   sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (c_ff),
      .wr_data (pix_ff),
      .rd_addr (c_cur),
      .rd_data (newer_rd)
   );

   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      sem_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (lane_ctrl[g]),
         .gain_sq (gain_sq_ff),
         .status  (lane_status[g])
      );
      assign mags[g] = lane_status[g].mag;
   end

   sem_merge u_merge (
      .color_mode (color_mode_ff),
      .mags       (mags),
      .edge_value (edge_in)
   );

   always_ff @(posedge clock) begin
      gain_sq_ff <= gain_ff * gain_ff;
      if (reset) begin
         state_ff        <= S_IDLE;
         color_mode_ff   <= 1'b0;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
         gain_ff         <= 8'd16;
         row_ff          <= '0;
         col_ff          <= '0;
         slot_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            cells_ff[k] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_COLOR_MODE:   color_mode_ff   <= csr_wdata[0];
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               CSR_GAIN:         gain_ff         <= csr_wdata[7:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  r_ff     <= r_cur;
                  c_ff     <= c_cur;
                  row_ff   <= row_in;
                  col_ff   <= col_in;
                  pix_ff   <= {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               for (int k = 0; k < 3; k++) begin
                  cells_ff[k*3]     <= cells_ff[k*3 + 1];
                  cells_ff[k*3 + 1] <= cells_ff[k*3 + 2];
               end
               cells_ff[2] <= older_rd;
               cells_ff[5] <= newer_rd;
               cells_ff[8] <= pix_ff;
               slot_ff     <= '0;
               state_ff    <= S_SLOT;
            end
            S_SLOT: begin
               if (slot_valid) begin
                  rsp_row_ff  <= orow[9:0];
                  rsp_col_ff  <= ocol[9:0];
                  rsp_last_ff <= (orow == h_eff - 11'd1) && (ocol == w_eff - 11'd1);
                  state_ff    <= S_CALC;
               end else if (slot_ff == 2'd3) begin
                  state_ff <= S_IDLE;
               end else begin
                  slot_ff <= slot_ff + 2'd1;
               end
            end
            S_CALC: begin
               if (lane_status[0].done) begin
                  rsp_edge_ff  <= edge_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (slot_ff == 2'd3) begin
                     state_ff <= S_IDLE;
                  end else begin
                     slot_ff  <= slot_ff + 2'd1;
                     state_ff <= S_SLOT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_edge_value = rsp_edge_ff;
   assign rsp_frame_last = rsp_last_ff;

   `SEM_ASSERT_SAME(a_no_accept_while_result, clock, reset, rsp_valid, !req_ready, "item taken while a result waits")
   `SEM_ASSERT_NEXT(a_result_leaves, clock, reset, rsp_valid && rsp_ready, !rsp_valid, "result repeated")
   `SEM_ASSERT_SAME(a_last_on_corner, clock, reset, rsp_valid && rsp_frame_last, ({1'b0, rsp_out_col} == w_eff - 11'd1) && ({1'b0, rsp_out_row} == h_eff - 11'd1), "frame end flag off the last pixel")
   `SEM_ASSERT_SAME(a_lanes_in_step, clock, reset, lane_status[0].done, lane_status[1].done && lane_status[2].done, "channel lanes out of step")

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
   import sem_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE      = 40;

   typedef struct {
      logic [9:0] row;
      logic [9:0] col;
      logic [7:0] edge_val;
      logic       last;
   } edge_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_pixel_ch0 = '0;
   logic [7:0]  req_pixel_ch1 = '0;
   logic [7:0]  req_pixel_ch2 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [9:0]  rsp_out_row;
   logic [9:0]  rsp_out_col;
   logic [7:0]  rsp_edge_value;
   logic        rsp_frame_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_COLOR_MODE;
   logic [10:0] csr_wdata = '0;

   sobel_edge_magnitude u_top (.*);

   always #5 clock = ~clock;

   // Shadow of the block: configuration, line stores, window and position.
   logic        cfg_color = 1'b0;
   logic [10:0] cfg_width = 11'd640;
   logic [10:0] cfg_height = 11'd480;
   logic [7:0]  cfg_gain = 8'd16;
   logic [23:0] upper_row [0:MAX_WIDTH-1];
   logic [23:0] lower_row [0:MAX_WIDTH-1];
   logic [23:0] win [0:8];
   int          cur_row = 0;
   int          cur_col = 0;

   logic [23:0]     pixel_queue[$];
   edge_result_type edge_queue[$];
   int              pushed = 0;
   int              accepted = 0;
   int              errors = 0;
   int              stall_cycles = 0;
   int              cycle = 0;
   logic            req_taken = 1'b0;

   function automatic int clamp_dim(logic [10:0] v);
      if (v < 2) return 2;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return v;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, cand;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         cand = root | (64'd1 << i);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   function automatic longint unsigned grad_mag(int t, int m, int b, int l, int c, int r,
                                                int ch);
      int gx, gy;
      longint unsigned e;
      gx = (win[t*3+r][8*ch +: 8] + 2 * win[m*3+r][8*ch +: 8] + win[b*3+r][8*ch +: 8])
         - (win[t*3+l][8*ch +: 8] + 2 * win[m*3+l][8*ch +: 8] + win[b*3+l][8*ch +: 8]);
      gy = (win[b*3+l][8*ch +: 8] + 2 * win[b*3+c][8*ch +: 8] + win[b*3+r][8*ch +: 8])
         - (win[t*3+l][8*ch +: 8] + 2 * win[t*3+c][8*ch +: 8] + win[t*3+r][8*ch +: 8]);
      e = longint'(gx * gx + gy * gy);
      return floor_sqrt(e * cfg_gain * cfg_gain) >> 4;
   endfunction

   function automatic void predict_edges(logic [23:0] pix);
      int w, h, r, c, ncols, oc, orow, l, cm, rr, t, m, b;
      int cols[2];
      longint unsigned v;
      edge_result_type res;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      ncols = 0;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= h) cur_row = 0;
      r = cur_row;
      c = cur_col;
      for (int k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = upper_row[c];
      win[5] = lower_row[c];
      win[8] = pix;
      upper_row[c] = lower_row[c];
      lower_row[c] = pix;
      if (r >= 1 && c >= 1) begin
         cols[ncols++] = c - 1;
         if (c == w - 1) cols[ncols++] = w - 1;
      end
      for (int i = 0; i < ncols; i++) begin
         oc = cols[i];
         if (oc == w - 1) begin
            l = 1; cm = 2; rr = 1;
         end else begin
            l = (oc == 0) ? 2 : 0; cm = 1; rr = 2;
         end
         for (int j = 0; j < 2; j++) begin
            if (j == 0) begin
               orow = r - 1;
               t = (orow == 0) ? 2 : 0; m = 1; b = 2;
            end else begin
               if (r != h - 1) break;
               orow = r;
               t = 1; m = 2; b = 1;
            end
            if (cfg_color)
               v = (grad_mag(t, m, b, l, cm, rr, 0) + grad_mag(t, m, b, l, cm, rr, 1)
                  + grad_mag(t, m, b, l, cm, rr, 2)) / 3;
            else
               v = grad_mag(t, m, b, l, cm, rr, 0);
            res.row = orow[9:0];
            res.col = oc[9:0];
            res.edge_val = (v > 255) ? 8'd255 : v[7:0];
            res.last = (orow == h - 1 && oc == w - 1);
            edge_queue.push_back(res);
         end
      end
      cur_col = c + 1;
      if (cur_col >= w) begin
         cur_col = 0;
         cur_row = r + 1;
         if (cur_row >= h) cur_row = 0;
      end
   endfunction

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_row[i] = '0;
         lower_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
   end

   // Prediction on input handshakes, checking on output handshakes, and the watchdog.
   always @(posedge clock) begin
      edge_result_type exp_res;
      cycle <= cycle + 1;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_edges({req_pixel_ch2, req_pixel_ch1, req_pixel_ch0});
            accepted <= accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (edge_queue.size() == 0) begin
               $error("unexpected item row=%0d col=%0d", rsp_out_row, rsp_out_col);
               errors++;
            end else begin
               exp_res = edge_queue.pop_front();
               if (rsp_out_row !== exp_res.row) begin
                  $error("out_row expected %0d got %0d", exp_res.row, rsp_out_row);
                  errors++;
               end
               if (rsp_out_col !== exp_res.col) begin
                  $error("out_col expected %0d got %0d", exp_res.col, rsp_out_col);
                  errors++;
               end
               if (rsp_edge_value !== exp_res.edge_val) begin
                  $error("edge_value expected %0d got %0d", exp_res.edge_val,
                         rsp_edge_value);
                  errors++;
               end
               if (rsp_frame_last !== exp_res.last) begin
                  $error("frame_last expected %0d got %0d", exp_res.last, rsp_frame_last);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
         else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end else
            stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic idle_now();
      if (cycle >= 1500 && cycle < 4500) return 1'b0;
      return $urandom_range(99) < 35;
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= !idle_now();
         if (!req_valid || req_taken) begin
            if (pixel_queue.size() != 0 && !idle_now()) begin
               {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0} <= pixel_queue.pop_front();
               req_valid <= 1'b1;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [10:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_COLOR_MODE:   cfg_color = val[0];
         CSR_FRAME_WIDTH:  cfg_width = val;
         CSR_FRAME_HEIGHT: cfg_height = val;
         default:          cfg_gain = val[7:0];
      endcase
   endtask

   task automatic wait_drained();
      wait (pixel_queue.size() == 0 && accepted == pushed && edge_queue.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // style 0: random, 1: only 0 and 255 per channel, 2: one flat value
   task automatic run_frame(logic color, logic [10:0] w, logic [10:0] h, logic [7:0] g,
                            int style);
      int n;
      logic [23:0] flat;
      wait_drained();
      write_reg(CSR_COLOR_MODE, {10'd0, color});
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_GAIN, {3'd0, g});
      @(negedge clock);
      csr_we <= 1'b0;
      n = clamp_dim(w) * clamp_dim(h);
      flat = 24'($urandom);
      for (int i = 0; i < n; i++) begin
         if (style == 1)
            pixel_queue.push_back({{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                                   {8{1'($urandom_range(1))}}});
         else if (style == 2)
            pixel_queue.push_back(flat);
         else
            pixel_queue.push_back(24'($urandom));
         pushed++;
      end
   endtask

   initial begin
      int total;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_frame(1'b0, 11'd2, 11'd2, 8'd0, 1);
      run_frame(1'b1, 11'd3, 11'd3, 8'd255, 1);
      run_frame(1'b0, 11'd0, 11'd1, 8'd16, 0);
      run_frame(1'b1, 11'd3, 11'd2, 8'd1, 2);

      total = 0;
      while (total < 185) begin
         logic [10:0] w, h;
         w = 11'($urandom_range(2, 9));
         h = 11'($urandom_range(2, 6));
         total += w * h;
         run_frame(1'($urandom_range(1)), w, h, 8'($urandom),
                   $urandom_range(9) == 0 ? 1 : 0);
      end

      wait_drained();
      if (errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_lane.sv
rtl/sem_merge.sv
rtl/sobel_edge_magnitude.sv
dv/tb.sv
